// File: design/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and codes for the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int unsigned LEVELS_DEF    = 3;
  localparam int unsigned MAX_TASKS_DEF = 16;

  localparam logic [31:0] SLICE0_RST = 32'd500;
  localparam logic [31:0] SLICE1_RST = 32'd1000;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [2:0] {
    EV_IDLE       = 3'd0,
    EV_DONE       = 3'd1,
    EV_DEMOTED    = 3'd2,
    EV_DISPATCHED = 3'd3,
    EV_REJECTED   = 3'd4
  } ev_e;

  typedef enum logic [0:0] {
    CFG_SLICE0 = 1'b0,
    CFG_SLICE1 = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_CHARGE,
    ST_DECIDE,
    ST_POP,
    ST_PTASK,
    ST_PDISP
  } state_e;

  // classified input word
  typedef struct packed {
    logic        is_tick;
    logic        id_bad;
    logic [3:0]  id;
    logic [31:0] need;
    logic [2:0]  lvl;
    logic [31:0] now;
  } item_t;

  // result word
  typedef struct packed {
    ev_e         res;
    logic [3:0]  task_id;
    logic [1:0]  level;
    logic [31:0] time_ms;
    logic        last;
  } emit_t;

  // front to back handoff
  typedef struct packed {
    logic  valid;
    item_t item;
  } fq_t;

endpackage

// File: design/mlfq_front.sv
// ----------------------------------------------------------------------------
// mlfq_front
// Input side: accepts words, clamps level, flags out-of-range ids, queues them.
// ----------------------------------------------------------------------------
module mlfq_front #(
  parameter int unsigned LEVELS    = mlfq_pkg::LEVELS_DEF,
  parameter int unsigned MAX_TASKS = mlfq_pkg::MAX_TASKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [mlfq_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic                           s_axis_tuser,
  output mlfq_pkg::fq_t                  fq_o,
  input  logic                           pop_i
);

  mlfq_pkg::item_t fifo_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  mlfq_pkg::item_t in_item;
  logic            push, pop;

  always_comb begin
    in_item.is_tick = s_axis_tuser;
    in_item.id      = s_axis_tdata[3:0];
    in_item.need    = s_axis_tdata[35:4];
    in_item.now     = s_axis_tdata[70:39];
    in_item.id_bad  = !(9'(s_axis_tdata[3:0]) < 9'(MAX_TASKS));
    if (4'(s_axis_tdata[38:36]) >= 4'(LEVELS)) begin
      in_item.lvl = 3'(LEVELS - 1);
    end else begin
      in_item.lvl = s_axis_tdata[38:36];
    end
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_item;
    end
  end

  assign fq_o.valid = (cnt_q != 2'd0);
  assign fq_o.item  = fifo_q[rd_ptr_q];

endmodule

// File: design/mlfq_back.sv
// ----------------------------------------------------------------------------
// mlfq_back
// Scheduling sequencer: level queues, task records, running slot, events.
// ----------------------------------------------------------------------------
module mlfq_back #(
  parameter int unsigned LEVELS    = mlfq_pkg::LEVELS_DEF,
  parameter int unsigned MAX_TASKS = mlfq_pkg::MAX_TASKS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [31:0]     cfg_data_i,
  input  mlfq_pkg::fq_t   fq_i,
  output logic            pop_o,
  input  logic            emit_ready_i,
  output logic            emit_valid_o,
  output mlfq_pkg::emit_t emit_o
);

  localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned SD = LEVELS * MAX_TASKS;
  localparam int unsigned SW = $clog2(SD);

  typedef struct packed {
    logic [31:0]   required;
    logic [31:0]   elapsed;
    logic [LW-1:0] level;
    logic [31:0]   slice_start;
    logic [31:0]   last_update;
  } rec_t;

  mlfq_pkg::state_e state_q, state_d;

  logic [31:0]   slice0_q, slice1_q;
  logic          active_q [MAX_TASKS];
  logic          run_valid_q;
  logic [IW-1:0] run_task_q;
  logic [IW-1:0] head_q [LEVELS];
  logic [CW-1:0] cnt_q  [LEVELS];

  mlfq_pkg::item_t cur_q;
  logic [31:0]     sum_q, sdiff_q;
  logic [IW-1:0]   nx_q;

  logic [IW-1:0] store_mem [SD];
  logic [IW-1:0] store_rdata_q;
  rec_t          rec_mem [MAX_TASKS];
  rec_t          rec_rdata_q;

  // control strobes
  logic          rec_re, rec_we;
  logic [IW-1:0] rec_raddr, rec_waddr;
  rec_t          rec_wdata;
  logic          st_re;
  logic [SW-1:0] st_raddr, st_waddr;
  logic          push_en, push_ok;
  logic [LW-1:0] push_lvl;
  logic [IW-1:0] push_task;
  logic          deq_en;
  logic          act_set, act_clr;
  logic [IW-1:0] act_idx;
  logic          run_set, run_clr;
  logic          charge_en;

  // derived values
  logic [IW-1:0] cur_idx;
  logic [LW-1:0] cur_lvl;
  logic          reject;
  logic          any_ne;
  logic [LW-1:0] top_lvl;
  logic [IW:0]   pos_sum;
  logic [IW-1:0] push_pos;
  logic [31:0]   delta, add_sum, sat_sum;
  logic          done, demote;
  logic [31:0]   quantum;

  assign cur_idx = IW'(cur_q.id);
  assign cur_lvl = LW'(cur_q.lvl);
  assign reject  = cur_q.id_bad || active_q[cur_idx];

  always_comb begin
    any_ne  = 1'b0;
    top_lvl = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cnt_q[l] != '0) begin
        any_ne  = 1'b1;
        top_lvl = LW'(l);
      end
    end
  end

  always_comb begin
    pos_sum = (IW + 1)'(head_q[push_lvl]) + (IW + 1)'(cnt_q[push_lvl]);
    if (pos_sum >= (IW + 1)'(MAX_TASKS)) begin
      push_pos = IW'(pos_sum - (IW + 1)'(MAX_TASKS));
    end else begin
      push_pos = IW'(pos_sum);
    end
    push_ok  = (cnt_q[push_lvl] < CW'(MAX_TASKS));
    st_waddr = SW'(SW'(push_lvl) * SW'(MAX_TASKS)) + SW'(push_pos);
  end

  // charge: saturate elapsed time
  always_comb begin
    delta   = cur_q.now - rec_rdata_q.last_update;
    add_sum = rec_rdata_q.elapsed + delta;
    sat_sum = (add_sum < delta) ? 32'hFFFF_FFFF : add_sum;
  end

  always_comb begin
    quantum = (rec_rdata_q.level == '0) ? slice0_q : slice1_q;
    done    = (sum_q >= rec_rdata_q.required);
    demote  = !done && (rec_rdata_q.level < LW'(LEVELS - 1)) && (sdiff_q >= quantum);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mlfq_pkg::ST_IDLE: begin
        if (fq_i.valid) begin
          if (!fq_i.item.is_tick) begin
            state_d = mlfq_pkg::ST_ARRIVE;
          end else if (run_valid_q) begin
            state_d = mlfq_pkg::ST_CHARGE;
          end else begin
            state_d = mlfq_pkg::ST_POP;
          end
        end
      end
      mlfq_pkg::ST_ARRIVE: begin
        if (emit_ready_i) state_d = mlfq_pkg::ST_IDLE;
      end
      mlfq_pkg::ST_CHARGE: state_d = mlfq_pkg::ST_DECIDE;
      mlfq_pkg::ST_DECIDE: begin
        if (emit_ready_i) begin
          if ((done && any_ne) || demote) begin
            state_d = mlfq_pkg::ST_POP;
          end else begin
            state_d = mlfq_pkg::ST_IDLE;
          end
        end
      end
      mlfq_pkg::ST_POP: begin
        if (any_ne) begin
          state_d = mlfq_pkg::ST_PTASK;
        end else if (emit_ready_i) begin
          state_d = mlfq_pkg::ST_IDLE;
        end
      end
      mlfq_pkg::ST_PTASK: state_d = mlfq_pkg::ST_PDISP;
      mlfq_pkg::ST_PDISP: begin
        if (emit_ready_i) state_d = mlfq_pkg::ST_IDLE;
      end
      default: state_d = mlfq_pkg::ST_IDLE;
    endcase
  end

  // outputs and strobes
  always_comb begin
    pop_o        = 1'b0;
    rec_re       = 1'b0;
    rec_raddr    = run_task_q;
    rec_we       = 1'b0;
    rec_waddr    = cur_idx;
    rec_wdata    = rec_rdata_q;
    st_re        = 1'b0;
    st_raddr     = SW'(SW'(top_lvl) * SW'(MAX_TASKS)) + SW'(head_q[top_lvl]);
    push_en      = 1'b0;
    push_lvl     = cur_lvl;
    push_task    = cur_idx;
    deq_en       = 1'b0;
    act_set      = 1'b0;
    act_clr      = 1'b0;
    act_idx      = cur_idx;
    run_set      = 1'b0;
    run_clr      = 1'b0;
    charge_en    = 1'b0;
    emit_valid_o = 1'b0;
    emit_o       = '{res: mlfq_pkg::EV_IDLE, task_id: 4'd0, level: 2'd0,
                     time_ms: cur_q.now, last: 1'b1};
    case (state_q)
      mlfq_pkg::ST_IDLE: begin
        pop_o  = fq_i.valid;
        rec_re = fq_i.valid && fq_i.item.is_tick && run_valid_q;
      end
      mlfq_pkg::ST_ARRIVE: begin
        emit_valid_o   = emit_ready_i;
        emit_o.task_id = cur_q.id;
        emit_o.level   = 2'(cur_lvl);
        emit_o.time_ms = 32'd0;
        if (reject) begin
          emit_o.res = mlfq_pkg::EV_REJECTED;
        end else begin
          rec_we                = emit_ready_i;
          rec_wdata.required    = cur_q.need;
          rec_wdata.elapsed     = 32'd0;
          rec_wdata.level       = cur_lvl;
          rec_wdata.slice_start = 32'd0;
          rec_wdata.last_update = 32'd0;
          push_en               = emit_ready_i;
          act_set               = emit_ready_i;
        end
      end
      mlfq_pkg::ST_CHARGE: charge_en = 1'b1;
      mlfq_pkg::ST_DECIDE: begin
        rec_waddr             = run_task_q;
        rec_wdata.elapsed     = sum_q;
        rec_wdata.last_update = cur_q.now;
        rec_we                = emit_ready_i;
        emit_valid_o          = emit_ready_i;
        emit_o.task_id        = 4'(run_task_q);
        if (done) begin
          act_idx        = run_task_q;
          act_clr        = emit_ready_i;
          run_clr        = emit_ready_i;
          emit_o.res     = mlfq_pkg::EV_DONE;
          emit_o.level   = 2'(rec_rdata_q.level);
          emit_o.last    = !any_ne;
        end else if (demote) begin
          rec_wdata.level = rec_rdata_q.level + LW'(1);
          push_lvl        = rec_rdata_q.level + LW'(1);
          push_task       = run_task_q;
          push_en         = emit_ready_i;
          run_clr         = emit_ready_i;
          emit_o.res      = mlfq_pkg::EV_DEMOTED;
          emit_o.level    = 2'(rec_rdata_q.level + LW'(1));
          emit_o.last     = 1'b0;
        end else begin
          emit_o.task_id = 4'd0;
        end
      end
      mlfq_pkg::ST_POP: begin
        if (any_ne) begin
          st_re  = 1'b1;
          deq_en = 1'b1;
        end else begin
          emit_valid_o = emit_ready_i;
        end
      end
      mlfq_pkg::ST_PTASK: begin
        rec_re    = 1'b1;
        rec_raddr = store_rdata_q;
      end
      mlfq_pkg::ST_PDISP: begin
        rec_waddr             = nx_q;
        rec_wdata.slice_start = cur_q.now;
        rec_wdata.last_update = cur_q.now;
        rec_we                = emit_ready_i;
        run_set               = emit_ready_i;
        emit_valid_o          = emit_ready_i;
        emit_o.res            = mlfq_pkg::EV_DISPATCHED;
        emit_o.task_id        = 4'(nx_q);
        emit_o.level          = 2'(rec_rdata_q.level);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlfq_pkg::ST_IDLE;
      slice0_q    <= mlfq_pkg::SLICE0_RST;
      slice1_q    <= mlfq_pkg::SLICE1_RST;
      run_valid_q <= 1'b0;
      run_task_q  <= '0;
      for (int t = 0; t < MAX_TASKS; t++) active_q[t] <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mlfq_pkg::CFG_SLICE0: slice0_q <= cfg_data_i;
          mlfq_pkg::CFG_SLICE1: slice1_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (act_set) active_q[act_idx] <= 1'b1;
      if (act_clr) active_q[act_idx] <= 1'b0;
      if (run_clr) run_valid_q <= 1'b0;
      if (run_set) begin
        run_valid_q <= 1'b1;
        run_task_q  <= nx_q;
      end
      if (push_en && push_ok) begin
        cnt_q[push_lvl] <= cnt_q[push_lvl] + CW'(1);
      end
      if (deq_en) begin
        cnt_q[top_lvl] <= cnt_q[top_lvl] - CW'(1);
        if (head_q[top_lvl] == IW'(MAX_TASKS - 1)) begin
          head_q[top_lvl] <= '0;
        end else begin
          head_q[top_lvl] <= head_q[top_lvl] + IW'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= fq_i.item;
    if (charge_en) begin
      sum_q   <= sat_sum;
      sdiff_q <= cur_q.now - rec_rdata_q.slice_start;
    end
    if (state_q == mlfq_pkg::ST_PTASK) nx_q <= store_rdata_q;
  end

  // queue store
  always_ff @(posedge clk_i) begin
    if (push_en && push_ok) store_mem[st_waddr] <= push_task;
    if (st_re) store_rdata_q <= store_mem[st_raddr];
  end

  // task records: hold write data in the read register too
  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[rec_waddr] <= rec_wdata;
    if (rec_re) begin
      rec_rdata_q <= rec_mem[rec_raddr];
    end else if (rec_we) begin
      rec_rdata_q <= rec_wdata;
    end
  end

endmodule

// File: design/mlfq_task_scheduler.sv
// ----------------------------------------------------------------------------
// mlfq_task_scheduler
// Multilevel feedback queue scheduler with one running slot.
// ----------------------------------------------------------------------------
// Input stream: tuser = cmd (0 arrival, 1 tick); tdata carries task, run
// time, start level and tick time. Each input word yields one or two result
// words on the output stream; tlast marks the final word of an input.
// tuser on the output carries the event code.
// The states each input word takes are set by the single-port task record
// memory and the queue store read: arrival IDLE, ARRIVE; tick with nothing
// running IDLE, POP; tick that charges IDLE, CHARGE, DECIDE; dispatch adds PTASK, PDISP after POP.
// A two-word input queue keeps accepting while the sequencer works, and a
// one-word output register lets the next result stand while the receiver
// holds tready low; the sequencer then waits in place.
// Reset clears the queues, active flags and running slot at once and loads
// the quanta with 500 and 1000 ms. The task store needs no clearing pass.
// Configuration: cfg_we_i writes cfg_data_i to the quantum at cfg_idx_i.
// ----------------------------------------------------------------------------
module mlfq_task_scheduler #(
  parameter int unsigned LEVELS    = mlfq_pkg::LEVELS_DEF,
  parameter int unsigned MAX_TASKS = mlfq_pkg::MAX_TASKS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [31:0]                     cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // task_id[3:0], run_time_ms[35:4], start_level[38:36], now_ms[70:39]
  input  logic [mlfq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // event_task[3:0], event_level[5:4], event_time_ms[37:6]
  output logic [mlfq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // event_res
  output logic [2:0]                      m_axis_tuser,
  output logic                            m_axis_tlast
);

  mlfq_pkg::fq_t   fq;
  logic            pop;
  logic            emit_valid, emit_ready;
  mlfq_pkg::emit_t emit;
  logic            out_valid_q;
  mlfq_pkg::emit_t out_q;

  mlfq_front #(.LEVELS(LEVELS), .MAX_TASKS(MAX_TASKS)) u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .fq_o (fq),
    .pop_i(pop)
  );

  mlfq_back #(.LEVELS(LEVELS), .MAX_TASKS(MAX_TASKS)) u_back (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fq_i        (fq),
    .pop_o       (pop),
    .emit_ready_i(emit_ready),
    .emit_valid_o(emit_valid),
    .emit_o      (emit)
  );

  assign emit_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid) out_q <= emit;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.time_ms, out_q.level, out_q.task_id};
  assign m_axis_tuser  = out_q.res;
  assign m_axis_tlast  = out_q.last;

  a_no_emit_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit_valid && out_valid_q && !m_axis_tready))
    else $error("result emitted while output register blocked");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> fq.valid)
    else $error("sequencer took a word from an empty input queue");

  a_final_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_valid && (emit.res == mlfq_pkg::EV_DISPATCHED ||
                    emit.res == mlfq_pkg::EV_REJECTED)) |-> emit.last)
    else $error("dispatch or reject not marked as final word");

endmodule

// File: dv/mlfq_task_scheduler_test.sv
// ----------------------------------------------------------------------------
// mlfq_task_scheduler_test
// Streams arrivals and ticks into the scheduler under random handshake
// stalls, predicts every event word and checks the output stream in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mlfq_task_scheduler_test;

  localparam int unsigned NUM_LEVELS = 3;
  localparam int unsigned WDOG_LIMIT = 20000;

  class sched_scoreboard;
    mlfq_pkg::emit_t expected_q[$];
    logic [31:0] quantum0;
    logic [31:0] quantum1;
    logic [3:0]  level_fifo[NUM_LEVELS][$];
    bit          active[16];
    logic [31:0] required[16];
    logic [31:0] elapsed[16];
    logic [31:0] slice_start[16];
    logic [31:0] last_update[16];
    logic [1:0]  task_lvl[16];
    bit          running;
    logic [3:0]  running_id;
    int          errors;

    function new();
      quantum0 = mlfq_pkg::SLICE0_RST;
      quantum1 = mlfq_pkg::SLICE1_RST;
      running  = 0;
      errors   = 0;
      foreach (active[i]) active[i] = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("mismatch: %s", msg);
    endtask

    function void add_event(mlfq_pkg::ev_e res, logic [3:0] tid, logic [1:0] lvl,
                            logic [31:0] t, logic fin);
      mlfq_pkg::emit_t e;
      e.res = res; e.task_id = tid; e.level = lvl; e.time_ms = t; e.last = fin;
      expected_q.push_back(e);
    endfunction

    // work out the event words caused by one accepted word
    function void note_input(bit is_tick, logic [3:0] id, logic [31:0] need,
                             logic [2:0] lv, logic [31:0] now);
      logic [1:0]  clamped;
      logic [3:0]  t;
      logic [31:0] delta;
      logic [32:0] sum;
      logic [31:0] quantum;
      int          n;
      n = 0;
      if (!is_tick) begin
        clamped = (lv >= NUM_LEVELS) ? 2'(NUM_LEVELS - 1) : lv[1:0];
        if (active[id]) begin
          add_event(mlfq_pkg::EV_REJECTED, id, clamped, 0, 1);
        end else begin
          active[id] = 1; required[id] = need; elapsed[id] = 0; task_lvl[id] = clamped;
          level_fifo[clamped].push_back(id);
          add_event(mlfq_pkg::EV_IDLE, id, clamped, 0, 1);
        end
        return;
      end
      if (running) begin
        t = running_id;
        delta = now - last_update[t];
        sum = {1'b0, elapsed[t]} + delta;
        elapsed[t] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        last_update[t] = now;
        if (elapsed[t] >= required[t]) begin
          active[t] = 0; running = 0;
          add_event(mlfq_pkg::EV_DONE, t, task_lvl[t], now, 0);
          n++;
        end else if (task_lvl[t] < NUM_LEVELS - 1) begin
          quantum = (task_lvl[t] == 0) ? quantum0 : quantum1;
          if (now - slice_start[t] >= quantum) begin
            task_lvl[t]++;
            level_fifo[task_lvl[t]].push_back(t);
            running = 0;
            add_event(mlfq_pkg::EV_DEMOTED, t, task_lvl[t], now, 0);
            n++;
          end
        end
      end
      if (!running) begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
          if (level_fifo[l].size() != 0) begin
            t = level_fifo[l].pop_front();
            slice_start[t] = now; last_update[t] = now;
            running_id = t; running = 1;
            add_event(mlfq_pkg::EV_DISPATCHED, t, task_lvl[t], now, 0);
            n++;
            break;
          end
        end
      end
      if (n == 0) add_event(mlfq_pkg::EV_IDLE, 0, 0, now, 1);
      else expected_q[$].last = 1;
    endfunction

    task check_result(mlfq_pkg::emit_t got);
      mlfq_pkg::emit_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word res=%0d task=%0d", got.res, got.task_id));
        return;
      end
      want = expected_q.pop_front();
      if (got.res !== want.res || got.task_id !== want.task_id ||
          got.level !== want.level || got.time_ms !== want.time_ms ||
          got.last !== want.last)
        report($sformatf("got res=%0d task=%0d lvl=%0d t=%0h last=%0b, want %0d %0d %0d %0h %0b",
                         got.res, got.task_id, got.level, got.time_ms, got.last,
                         want.res, want.task_id, want.level, want.time_ms, want.last));
    endtask
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic                            cfg_idx_i;
  logic [31:0]                     cfg_data_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [mlfq_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                            s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [mlfq_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [2:0]                      m_axis_tuser;
  logic                            m_axis_tlast;

  sched_scoreboard sb = new();
  int              tx_idle_pct;
  int              rx_idle_pct;
  int              quiet_cycles = 0;
  logic [31:0]     clock_ms;

  mlfq_task_scheduler dut (.*);

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

  always @(posedge clk_i) begin
    mlfq_pkg::emit_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.res     = mlfq_pkg::ev_e'(m_axis_tuser);
      got.task_id = m_axis_tdata[3:0];
      got.level   = m_axis_tdata[5:4];
      got.time_ms = m_axis_tdata[37:6];
      got.last    = m_axis_tlast;
      sb.check_result(got);
    end
  end

  // end the run when no word moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("FAIL mlfq_task_scheduler");
      $finish;
    end
  end

  task send_word(bit is_tick, logic [3:0] id, logic [31:0] need, logic [2:0] lv,
                 logic [31:0] now);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= is_tick;
    s_axis_tdata  <= {1'b0, now, lv, need, id};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(is_tick, id, need, lv, now);
  endtask

  task send_tick(logic [31:0] step);
    clock_ms = clock_ms + step;
    send_word(1, 0, 0, 0, clock_ms);
  endtask

  // hold input until every expected word is out, then let the pipe settle
  task drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task write_quantum(mlfq_pkg::cfg_idx_e idx, logic [31:0] value);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (idx == mlfq_pkg::CFG_SLICE0) sb.quantum0 = value;
    else sb.quantum1 = value;
  endtask

  task random_word();
    int r;
    logic [31:0] need;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      r = $urandom_range(0, 99);
      need = (r < 10) ? 32'd0 : (r < 16) ? $urandom : 32'($urandom_range(1, 4000));
      send_word(0, 4'($urandom_range(0, 15)), need, 3'($urandom_range(0, 7)), 0);
    end else begin
      r = $urandom_range(0, 99);
      send_tick((r < 6) ? $urandom : 32'($urandom_range(0, 1200)));
    end
  endtask

  initial begin
    logic [31:0] q0, q1;
    rst_ni = 0; cfg_we_i = 0; cfg_idx_i = mlfq_pkg::CFG_SLICE0; cfg_data_i = 0;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
    clock_ms = 100;
    tx_idle_pct = 34; rx_idle_pct = 72;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: clamping, duplicates, zero and maximal run time, wrap, saturation
    send_word(0, 0, 0, 0, 0);
    send_word(0, 0, 5, 1, 0);
    send_word(0, 15, 32'hFFFF_FFFF, 7, 0);
    send_word(0, 5, 700, 1, 0);
    send_word(0, 6, 2000, 3, 0);
    send_word(0, 9, 300, 0, 0);
    send_tick(0);
    send_tick(0);
    send_tick(1200);
    send_tick(600);
    send_tick(32'hFFFF_FF00);
    send_tick(32'h200);
    send_tick(1500);
    send_tick(32'h7FFF_FFFF);
    send_tick(32'h7FFF_FFFF);
    send_tick(32'h7FFF_FFFF);
    send_tick(32'h7FFF_FFFF);
    send_word(0, 15, 1, 2, 0);
    send_tick(5);
    send_tick(5);

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin q0 = 1;            q1 = 1;            end
        1: begin q0 = 32'hFFFF_FFFF; q1 = 32'hFFFF_FFFF; end
        2: begin q0 = 1;            q1 = 32'hFFFF_FFFF; end
        3: begin q0 = 32'hFFFF_FFFF; q1 = 1;            end
        4: begin q0 = $urandom;     q1 = $urandom;     end
        default: begin q0 = 32'($urandom_range(1, 800)); q1 = 32'($urandom_range(1, 1600)); end
      endcase
      if (q0 == 0) q0 = 1;
      if (q1 == 0) q1 = 1;
      write_quantum(mlfq_pkg::CFG_SLICE0, q0);
      write_quantum(mlfq_pkg::CFG_SLICE1, q1);
      for (int i = 0; i < 140; i++) begin
        if (p == 2 && i == 0) begin
          tx_idle_pct = 72; rx_idle_pct = 34;
        end
        if (p == 4 && i == 0) begin
          tx_idle_pct = 0; rx_idle_pct = 0;
        end
        random_word();
      end
    end

    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("PASS mlfq_task_scheduler");
    else
      $display("FAIL mlfq_task_scheduler");
    $finish;
  end

endmodule

// File: files.f
design/mlfq_pkg.sv
design/mlfq_front.sv
design/mlfq_back.sv
design/mlfq_task_scheduler.sv
dv/mlfq_task_scheduler_test.sv
